// ===== rtl/sufs_pkg.sv =====
// Package of the sound unit frame sequencer: register indexes, decoded
// command type, read masks and helper functions. No dependencies.
package sufs_pkg;

  localparam int WAVE_RAM_BYTES = 16;
  localparam int WAVE_AW = $clog2(WAVE_RAM_BYTES);
  localparam int NUM_REGS = 21;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    R_SQA_SWEEP = 5'd0, R_SQA_DUTY = 5'd1, R_SQA_ENV = 5'd2, R_SQA_FLO = 5'd3,
    R_SQA_FHI = 5'd4, R_SQB_DUTY = 5'd5, R_SQB_ENV = 5'd6, R_SQB_FLO = 5'd7,
    R_SQB_FHI = 5'd8, R_WAV_ON = 5'd9, R_WAV_LEN = 5'd10, R_WAV_LVL = 5'd11,
    R_WAV_FLO = 5'd12, R_WAV_FHI = 5'd13, R_NOI_LEN = 5'd14, R_NOI_ENV = 5'd15,
    R_NOI_POLY = 5'd16, R_NOI_CTL = 5'd17, R_MIX_VOL = 5'd18, R_MIX_PAN = 5'd19,
    R_PWR_CTL = 5'd20, R_NONE = 5'd31
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_REG  = 2'd1,
    K_WAVE = 2'd2
  } target_t;

  typedef struct packed {
    op_t          op;
    target_t      target;
    reg_idx_t     idx;
    logic [WAVE_AW-1:0] wave_addr;
    logic [7:0]   data;
    logic [7:0]   cycles;
  } cmd_t;

  function automatic reg_idx_t map_addr(input logic [4:0] off);
    reg_idx_t r;
    unique case (off)
      5'd0: r = R_SQA_SWEEP;  5'd1: r = R_SQA_DUTY;  5'd2: r = R_SQA_ENV;
      5'd3: r = R_SQA_FLO;    5'd4: r = R_SQA_FHI;   5'd6: r = R_SQB_DUTY;
      5'd7: r = R_SQB_ENV;    5'd8: r = R_SQB_FLO;   5'd9: r = R_SQB_FHI;
      5'd10: r = R_WAV_ON;    5'd11: r = R_WAV_LEN;  5'd12: r = R_WAV_LVL;
      5'd13: r = R_WAV_FLO;   5'd14: r = R_WAV_FHI;  5'd16: r = R_NOI_LEN;
      5'd17: r = R_NOI_ENV;   5'd18: r = R_NOI_POLY; 5'd19: r = R_NOI_CTL;
      5'd20: r = R_MIX_VOL;   5'd21: r = R_MIX_PAN;  5'd22: r = R_PWR_CTL;
      default: r = R_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] read_or(input reg_idx_t i);
    logic [7:0] v;
    unique case (i)
      R_SQA_SWEEP: v = 8'h80;
      R_SQA_DUTY, R_SQB_DUTY: v = 8'h3F;
      R_SQA_FLO, R_SQB_FLO, R_WAV_LEN, R_WAV_FLO, R_NOI_LEN: v = 8'hFF;
      R_SQA_FHI, R_SQB_FHI, R_WAV_FHI, R_NOI_CTL: v = 8'hBF;
      R_WAV_ON: v = 8'h7F;
      R_WAV_LVL: v = 8'h9F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] wave_init(input int i);
    return (i % 2 == 1) ? 8'hFF : 8'h00;
  endfunction

endpackage

// ===== rtl/sound_unit_frame_sequencer_top.sv =====
// A transaction's result passes through the queue and then the back part's
// output register before it is on the outputs.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: synchronous rst clears state to power-up values, threshold 8192.
// Top level; depends on sufs_pkg, sufs_front, sufs_queue and sufs_back.
module sound_unit_frame_sequencer_top import sufs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycles,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [3:0]  ready_mask,
  output logic [3:0]  volume_square_a,
  output logic [3:0]  volume_square_b,
  output logic [3:0]  volume_noise,
  output logic [2:0]  volume_changed,
  output logic [15:0] sweep_frequency
);
  cmd_t fcmd, qcmd;
  logic full, empty, take;
  logic [15:0] threshold;

  assign cfg_ready = 1'b1;
  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd8192;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  sufs_front u_front (.op, .address, .write_data, .cycles, .cmd(fcmd));

  sufs_queue u_queue (
    .clk, .rst, .push(in_valid && !in_stall), .push_cmd(fcmd), .full,
    .pop(take), .empty, .head(qcmd)
  );

  sufs_back u_back (
    .clk, .rst, .threshold, .cmd_valid(!empty), .cmd(qcmd), .cmd_take(take),
    .out_valid, .out_stall, .read_data, .ready_mask, .volume_square_a,
    .volume_square_b, .volume_noise, .volume_changed, .sweep_frequency
  );
endmodule

// ===== rtl/sufs_front.sv =====
// Front part: decodes the address and operation of input transactions
// into a command. Depends on sufs_pkg.
module sufs_front import sufs_pkg::*; (
  input  logic [1:0]  op,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycles,
  output cmd_t        cmd
);
  always_comb begin
    cmd.op = op_t'(op);
    cmd.data = write_data;
    cmd.cycles = cycles;
    cmd.wave_addr = address[WAVE_AW-1:0];
    cmd.idx = R_NONE;
    if (address >= 16'hFF30 && address < 16'(32'hFF30 + WAVE_RAM_BYTES)) begin
      cmd.target = K_WAVE;
    end else if (address >= 16'hFF10 && address <= 16'hFF26) begin
      cmd.idx = map_addr(5'(address - 16'hFF10));
      cmd.target = (cmd.idx == R_NONE) ? K_NONE : K_REG;
    end else begin
      cmd.target = K_NONE;
    end
  end
endmodule

// ===== rtl/sufs_queue.sv =====
// Short command queue between front and back parts.
// Depends on sufs_pkg.
module sufs_queue import sufs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  cmd_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wr, rd;
  logic [PW:0] count;

  assign full = count == (PW+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head = mem[rd];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_cmd;
    end
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= wr + 1'b1;
      end
      if (pop) begin
        rd <= rd + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif
endmodule

// ===== rtl/sufs_back.sv =====
// Back part: register file, wave RAM, length counters, envelopes, sweep
// and frame sequencer; one command per cycle into an output register while the output is not stalled.
// Depends on sufs_pkg.
module sufs_back import sufs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] threshold,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [3:0]  ready_mask,
  output logic [3:0]  volume_square_a,
  output logic [3:0]  volume_square_b,
  output logic [3:0]  volume_noise,
  output logic [2:0]  volume_changed,
  output logic [15:0] sweep_frequency
);
  logic [7:0]  regs [NUM_REGS];
  logic [7:0]  wave [WAVE_RAM_BYTES];
  logic [23:0] acc;
  logic [2:0]  step;
  logic [8:0]  len [4];
  logic [2:0]  eper [3];
  logic [3:0]  evol [3];
  logic [2:0]  scnt;
  logic [15:0] shadow;
  logic        sen;
  logic [3:0]  rdy;

  logic [7:0]  regs_next [NUM_REGS];
  logic [7:0]  wave_next [WAVE_RAM_BYTES];
  logic [23:0] acc_next;
  logic [2:0]  step_next;
  logic [8:0]  len_next [4];
  logic [2:0]  eper_next [3];
  logic [3:0]  evol_next [3];
  logic [2:0]  scnt_next;
  logic [15:0] shadow_next;
  logic        sen_next;
  logic [3:0]  rdy_next;
  logic [7:0]  rd;
  logic [2:0]  chg;

  assign cmd_take = cmd_valid && (!out_valid || !out_stall);

  localparam reg_idx_t ENV_R [3] = '{R_SQA_ENV, R_SQB_ENV, R_NOI_ENV};
  localparam reg_idx_t CTL_R [4] = '{R_SQA_FHI, R_SQB_FHI, R_WAV_FHI, R_NOI_CTL};
  localparam reg_idx_t LEN_R [4] = '{R_SQA_DUTY, R_SQB_DUTY, R_WAV_LEN, R_NOI_LEN};

  always_comb begin
    logic [24:0] sum;
    logic [15:0] d, nx;
    logic [7:0]  s, n;
    logic [1:0]  trig;
    logic        do_trig;
    regs_next = regs;
    wave_next = wave;
    acc_next = acc;
    step_next = step;
    len_next = len;
    eper_next = eper;
    evol_next = evol;
    scnt_next = scnt;
    shadow_next = shadow;
    sen_next = sen;
    rdy_next = rdy;
    rd = 8'hFF;
    chg = '0;
    sum = '0;
    d = '0;
    nx = '0;
    s = regs[R_SQA_SWEEP];
    n = '0;
    trig = '0;
    do_trig = 1'b0;
    unique case (cmd.op)
      OP_READ: begin
        if (cmd.target == K_WAVE) begin
          rd = wave[cmd.wave_addr];
        end else if (cmd.target == K_REG) begin
          if (cmd.idx == R_PWR_CTL) begin
            rd = regs[R_PWR_CTL] | ((regs[R_NOI_CTL] >> 4) & 8'h08)
              | (((regs[R_WAV_FHI] & regs[R_WAV_ON]) >> 5) & 8'h04)
              | ((regs[R_SQB_FHI] >> 6) & 8'h02) | (regs[R_SQA_FHI] >> 7) | 8'h70;
          end else begin
            rd = regs[cmd.idx] | read_or(cmd.idx);
          end
        end
      end
      OP_WRITE: begin
        if (cmd.target == K_WAVE) begin
          wave_next[cmd.wave_addr] = cmd.data;
        end else if (cmd.target == K_REG && cmd.idx == R_PWR_CTL) begin
          for (int i = 0; i < NUM_REGS; i++) begin
            regs_next[i] = '0;
          end
          regs_next[R_PWR_CTL] = cmd.data & 8'h80;
          for (int i = 0; i < WAVE_RAM_BYTES; i++) begin
            wave_next[i] = wave_init(i);
          end
          if (!cmd.data[7]) begin
            rdy_next = 4'hF;
          end
        end else if (cmd.target == K_REG) begin
          regs_next[cmd.idx] = cmd.data;
          unique case (cmd.idx)
            R_SQA_SWEEP: begin
              s = cmd.data;
              scnt_next = s[6:4];
              shadow_next = {5'd0, regs[R_SQA_FHI][2:0], regs[R_SQA_FLO]};
              sen_next = (s & 8'h77) != 0;
              d = shadow_next >> s[2:0];
              nx = s[3] ? shadow_next - d : shadow_next + d;
              if (s[2:0] != 0 && nx > 16'h07FF) begin
                sen_next = 1'b0;
                regs_next[R_SQA_FHI][7] = 1'b0;
              end
              rdy_next[0] = 1'b1;
            end
            R_SQA_ENV: begin
              eper_next[0] = cmd.data[2:0];
              evol_next[0] = cmd.data[7:4];
              rdy_next[0] = 1'b1;
            end
            R_SQB_ENV: begin
              eper_next[1] = cmd.data[2:0];
              evol_next[1] = cmd.data[7:4];
              rdy_next[1] = 1'b1;
            end
            R_NOI_ENV: begin
              eper_next[2] = cmd.data[2:0];
              evol_next[2] = cmd.data[7:4];
              rdy_next[3] = 1'b1;
            end
            R_WAV_ON, R_WAV_LVL: rdy_next[2] = 1'b1;
            R_SQA_FHI: begin trig = 2'd0; do_trig = cmd.data[7]; end
            R_SQB_FHI: begin trig = 2'd1; do_trig = cmd.data[7]; end
            R_WAV_FHI: begin trig = 2'd2; do_trig = cmd.data[7]; end
            R_NOI_CTL: begin trig = 2'd3; do_trig = cmd.data[7]; end
            default: ;
          endcase
          if (do_trig) begin
            n = regs[LEN_R[trig]];
            if (trig == 2'd2) begin
              len_next[2] = (n == 0) ? 9'h100 : {1'b0, n};
            end else begin
              len_next[trig] = (n[5:0] == 0) ? 9'h040 : {3'd0, n[5:0]};
            end
            rdy_next[trig] = 1'b1;
            if (trig == 2'd0) begin
              scnt_next = s[6:4];
              shadow_next = {5'd0, cmd.data[2:0], regs[R_SQA_FLO]};
              sen_next = (s & 8'h77) != 0;
              d = shadow_next >> s[2:0];
              nx = s[3] ? shadow_next - d : shadow_next + d;
              if (s[2:0] != 0 && nx > 16'h07FF) begin
                sen_next = 1'b0;
                regs_next[R_SQA_FHI][7] = 1'b0;
              end
              eper_next[0] = regs[R_SQA_ENV][2:0];
              evol_next[0] = regs[R_SQA_ENV][7:4];
            end else if (trig == 2'd1) begin
              eper_next[1] = regs[R_SQB_ENV][2:0];
              evol_next[1] = regs[R_SQB_ENV][7:4];
            end else if (trig == 2'd3) begin
              eper_next[2] = regs[R_NOI_ENV][2:0];
              evol_next[2] = regs[R_NOI_ENV][7:4];
            end
          end
        end
      end
      OP_TICK: begin
        sum = {1'b0, acc} + 25'(cmd.cycles);
        acc_next = sum[24] ? 24'hFFFFFF : sum[23:0];
        if (acc_next >= 24'(threshold)) begin
          acc_next = acc_next - 24'(threshold);
          step_next = step + 3'd1;
          if (!step_next[0]) begin
            for (int i = 0; i < 4; i++) begin
              if (regs[CTL_R[i]][6] && len[i] != 0) begin
                len_next[i] = len[i] - 9'd1;
                if (len_next[i] == 0) begin
                  regs_next[CTL_R[i]][7] = 1'b0;
                  rdy_next[i] = 1'b1;
                end
              end
            end
          end
          if (step_next == 3'd7) begin
            for (int i = 0; i < 3; i++) begin
              if (regs[ENV_R[i]][2:0] != 0) begin
                eper_next[i] = eper[i] - 3'd1;
                if (eper_next[i] == 0) begin
                  eper_next[i] = regs[ENV_R[i]][2:0];
                  if (regs[ENV_R[i]][3] && evol[i] != 4'd15) begin
                    evol_next[i] = evol[i] + 4'd1;
                  end
                  if (!regs[ENV_R[i]][3] && evol[i] != 0) begin
                    evol_next[i] = evol[i] - 4'd1;
                  end
                  chg[i] = 1'b1;
                end
              end
            end
          end
          if (step_next[1:0] == 2'd2 && s[6:4] != 0 && sen) begin
            scnt_next = scnt - 3'd1;
            if (scnt_next == 0) begin
              d = shadow >> s[2:0];
              shadow_next = s[3] ? shadow - d : shadow + d;
              if (shadow_next > 16'h07FF) begin
                regs_next[R_SQA_FHI][7] = 1'b0;
              end
              scnt_next = s[6:4];
              rdy_next[0] = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: rdy_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      for (int i = 0; i < WAVE_RAM_BYTES; i++) begin
        wave[i] <= wave_init(i);
      end
      for (int i = 0; i < 4; i++) begin
        len[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        eper[i] <= '0;
        evol[i] <= '0;
      end
      acc <= '0;
      step <= '0;
      scnt <= '0;
      shadow <= '0;
      sen <= 1'b0;
      rdy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        regs <= regs_next;
        wave <= wave_next;
        len <= len_next;
        eper <= eper_next;
        evol <= evol_next;
        acc <= acc_next;
        step <= step_next;
        scnt <= scnt_next;
        shadow <= shadow_next;
        sen <= sen_next;
        rdy <= rdy_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      read_data <= rd;
      ready_mask <= rdy_next;
      volume_square_a <= evol_next[0];
      volume_square_b <= evol_next[1];
      volume_noise <= evol_next[2];
      volume_changed <= chg;
      sweep_frequency <= shadow_next;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(ready_mask))
    else $error("stalled result changed");
  a_rdy_out: assert property (@(posedge clk) disable iff (rst)
    $past(cmd_take) |-> ready_mask == rdy) else $error("ready mask mismatch");
  a_vol_out: assert property (@(posedge clk) disable iff (rst)
    $past(cmd_take) |-> volume_square_a == evol[0] && sweep_frequency == shadow)
    else $error("output snapshot mismatch");
`endif
endmodule

// ===== dv/sufs_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sound unit frame sequencer: watches the input, threshold and result
// channels, predicts each result from its own copy of the block state and compares them.
// Depends on sufs_pkg for the operation codes and register indexes.
module sufs_checker import sufs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycles,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_data,
  input  logic [3:0]  ready_mask,
  input  logic [3:0]  volume_square_a,
  input  logic [3:0]  volume_square_b,
  input  logic [3:0]  volume_noise,
  input  logic [2:0]  volume_changed,
  input  logic [15:0] sweep_frequency,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  rd;
    logic [3:0]  mask;
    logic [3:0]  vol_a;
    logic [3:0]  vol_b;
    logic [3:0]  vol_n;
    logic [2:0]  changed;
    logic [15:0] sweep;
  } sound_result_t;

  sound_result_t expected_results[$];

  logic [15:0] threshold;
  logic [7:0]  regs [NUM_REGS];
  logic [7:0]  wave_mem [WAVE_RAM_BYTES];
  int          accum;
  logic [2:0]  seq_step;
  logic [8:0]  len_cnt [4];
  logic [2:0]  env_period [3];
  logic [3:0]  env_volume [3];
  logic [2:0]  sweep_cnt;
  logic [15:0] shadow_freq;
  logic        sweep_on;
  logic [3:0]  ready_bits;

  function automatic reg_idx_t decode_reg(input logic [15:0] a);
    reg_idx_t r;
    r = R_NONE;
    if (a >= 16'hFF10 && a <= 16'hFF26) begin
      case (a[5:0] - 6'h10)
        6'd0: r = R_SQA_SWEEP;  6'd1: r = R_SQA_DUTY;  6'd2: r = R_SQA_ENV;
        6'd3: r = R_SQA_FLO;    6'd4: r = R_SQA_FHI;   6'd6: r = R_SQB_DUTY;
        6'd7: r = R_SQB_ENV;    6'd8: r = R_SQB_FLO;   6'd9: r = R_SQB_FHI;
        6'd10: r = R_WAV_ON;    6'd11: r = R_WAV_LEN;  6'd12: r = R_WAV_LVL;
        6'd13: r = R_WAV_FLO;   6'd14: r = R_WAV_FHI;  6'd16: r = R_NOI_LEN;
        6'd17: r = R_NOI_ENV;   6'd18: r = R_NOI_POLY; 6'd19: r = R_NOI_CTL;
        6'd20: r = R_MIX_VOL;   6'd21: r = R_MIX_PAN;  6'd22: r = R_PWR_CTL;
        default: r = R_NONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] fixed_ones(input reg_idx_t i);
    case (i)
      R_SQA_SWEEP: return 8'h80;
      R_SQA_DUTY, R_SQB_DUTY: return 8'h3F;
      R_SQA_FLO, R_SQB_FLO, R_WAV_LEN, R_WAV_FLO, R_NOI_LEN: return 8'hFF;
      R_SQA_FHI, R_SQB_FHI, R_WAV_FHI, R_NOI_CTL: return 8'hBF;
      R_WAV_ON: return 8'h7F;
      R_WAV_LVL: return 8'h9F;
      default: return 8'h00;
    endcase
  endfunction

  function automatic reg_idx_t envelope_reg(input int ch);
    case (ch)
      0: return R_SQA_ENV;
      1: return R_SQB_ENV;
      default: return R_NOI_ENV;
    endcase
  endfunction

  function automatic reg_idx_t control_reg(input int ch);
    case (ch)
      0: return R_SQA_FHI;
      1: return R_SQB_FHI;
      2: return R_WAV_FHI;
      default: return R_NOI_CTL;
    endcase
  endfunction

  function automatic void power_clear();
    for (int i = 0; i < NUM_REGS; i++)
      if (i != R_PWR_CTL) regs[i] = 8'h00;
    for (int i = 0; i < WAVE_RAM_BYTES; i++)
      wave_mem[i] = i[0] ? 8'hFF : 8'h00;
  endfunction

  function automatic void reset_state();
    threshold = 16'd8192;
    for (int i = 0; i < NUM_REGS; i++) regs[i] = 8'h00;
    power_clear();
    accum = 0;
    seq_step = 3'd0;
    for (int i = 0; i < 4; i++) len_cnt[i] = 9'd0;
    for (int i = 0; i < 3; i++) begin
      env_period[i] = 3'd0;
      env_volume[i] = 4'd0;
    end
    sweep_cnt = 3'd0;
    shadow_freq = 16'd0;
    sweep_on = 1'b0;
    ready_bits = 4'd0;
  endfunction

  function automatic void load_envelope(input int ch);
    logic [7:0] r;
    r = regs[envelope_reg(ch)];
    env_period[ch] = r[2:0];
    env_volume[ch] = r[7:4];
  endfunction

  function automatic logic [15:0] swept_freq();
    logic [7:0]  s;
    logic [15:0] d;
    s = regs[R_SQA_SWEEP];
    d = shadow_freq >> s[2:0];
    return s[3] ? shadow_freq - d : shadow_freq + d;
  endfunction

  function automatic void load_sweep();
    logic [7:0] s;
    s = regs[R_SQA_SWEEP];
    sweep_cnt = s[6:4];
    shadow_freq = {5'd0, regs[R_SQA_FHI][2:0], regs[R_SQA_FLO]};
    sweep_on = (s & 8'h77) != 0;
    if (s[2:0] != 0 && swept_freq() > 16'h7FF) begin
      sweep_on = 1'b0;
      regs[R_SQA_FHI][7] = 1'b0;
    end
  endfunction

  function automatic void start_channel(input int ch);
    logic [7:0] n;
    case (ch)
      0: begin
        n = regs[R_SQA_DUTY] & 8'h3F;
        len_cnt[0] = (n != 0) ? {1'b0, n} : 9'h40;
        load_sweep();
        load_envelope(0);
      end
      1: begin
        n = regs[R_SQB_DUTY] & 8'h3F;
        len_cnt[1] = (n != 0) ? {1'b0, n} : 9'h40;
        load_envelope(1);
      end
      2: begin
        n = regs[R_WAV_LEN];
        len_cnt[2] = (n != 0) ? {1'b0, n} : 9'h100;
      end
      default: begin
        n = regs[R_NOI_LEN] & 8'h3F;
        len_cnt[3] = (n != 0) ? {1'b0, n} : 9'h40;
        load_envelope(2);
      end
    endcase
    ready_bits[ch] = 1'b1;
  endfunction

  function automatic logic [7:0] bus_read(input logic [15:0] a);
    reg_idx_t i;
    logic [7:0] r;
    if (a >= 16'hFF30 && a <= 16'hFF3F) return wave_mem[a[3:0]];
    i = decode_reg(a);
    if (i == R_NONE) return 8'hFF;
    r = regs[i];
    if (i == R_PWR_CTL)
      return r | {4'b0111, regs[R_NOI_CTL][7], regs[R_WAV_FHI][7] & regs[R_WAV_ON][7],
                  regs[R_SQB_FHI][7], regs[R_SQA_FHI][7]};
    return r | fixed_ones(i);
  endfunction

  function automatic void bus_write(input logic [15:0] a, input logic [7:0] d);
    reg_idx_t i;
    if (a >= 16'hFF30 && a <= 16'hFF3F) begin
      wave_mem[a[3:0]] = d;
      return;
    end
    i = decode_reg(a);
    if (i == R_NONE) return;
    if (i == R_PWR_CTL) begin
      regs[R_PWR_CTL] = d & 8'h80;
      power_clear();
      if (!d[7]) ready_bits = 4'hF;
      return;
    end
    regs[i] = d;
    case (i)
      R_SQA_SWEEP: begin load_sweep(); ready_bits[0] = 1'b1; end
      R_SQA_ENV: begin load_envelope(0); ready_bits[0] = 1'b1; end
      R_SQA_FHI: if (d[7]) start_channel(0);
      R_SQB_ENV: begin load_envelope(1); ready_bits[1] = 1'b1; end
      R_SQB_FHI: if (d[7]) start_channel(1);
      R_WAV_ON, R_WAV_LVL: ready_bits[2] = 1'b1;
      R_WAV_FHI: if (d[7]) start_channel(2);
      R_NOI_ENV: begin load_envelope(2); ready_bits[3] = 1'b1; end
      R_NOI_CTL: if (d[7]) start_channel(3);
      default: ;
    endcase
  endfunction

  function automatic void clock_lengths();
    reg_idx_t c;
    for (int i = 0; i < 4; i++) begin
      c = control_reg(i);
      if (regs[c][6] && len_cnt[i] != 0) begin
        len_cnt[i] = len_cnt[i] - 9'd1;
        if (len_cnt[i] == 0) begin
          regs[c][7] = 1'b0;
          ready_bits[i] = 1'b1;
        end
      end
    end
  endfunction

  function automatic logic [2:0] clock_envelopes();
    logic [2:0] changed;
    logic [7:0] r;
    changed = 3'd0;
    for (int i = 0; i < 3; i++) begin
      r = regs[envelope_reg(i)];
      if (r[2:0] != 0) begin
        env_period[i] = env_period[i] - 3'd1;
        if (env_period[i] == 0) begin
          env_period[i] = r[2:0];
          if (r[3] && env_volume[i] < 4'd15) env_volume[i] = env_volume[i] + 4'd1;
          if (!r[3] && env_volume[i] != 0) env_volume[i] = env_volume[i] - 4'd1;
          changed[i] = 1'b1;
        end
      end
    end
    return changed;
  endfunction

  function automatic void clock_sweep();
    logic [7:0] s;
    s = regs[R_SQA_SWEEP];
    if (s[6:4] == 0 || !sweep_on) return;
    sweep_cnt = sweep_cnt - 3'd1;
    if (sweep_cnt != 0) return;
    shadow_freq = swept_freq();
    if (shadow_freq > 16'h7FF) regs[R_SQA_FHI][7] = 1'b0;
    sweep_cnt = s[6:4];
    ready_bits[0] = 1'b1;
  endfunction

  function automatic logic [2:0] advance_cycles(input logic [7:0] cyc);
    logic [2:0] changed;
    changed = 3'd0;
    accum = accum + cyc;
    if (accum > 24'hFFFFFF) accum = 24'hFFFFFF;
    if (accum < threshold) return changed;
    accum = accum - threshold;
    seq_step = seq_step + 3'd1;
    if (!seq_step[0]) clock_lengths();
    if (seq_step == 3'd7) changed = clock_envelopes();
    if (seq_step[1:0] == 2'd2) clock_sweep();
    return changed;
  endfunction

  function automatic sound_result_t predict_result(input logic [1:0] o, input logic [15:0] a,
                                                   input logic [7:0] d, input logic [7:0] cyc);
    sound_result_t res;
    res = '0;
    res.rd = 8'hFF;
    case (o)
      OP_READ: res.rd = bus_read(a);
      OP_WRITE: bus_write(a, d);
      OP_TICK: res.changed = advance_cycles(cyc);
      default: ready_bits = 4'd0;
    endcase
    res.mask = ready_bits;
    res.vol_a = env_volume[0];
    res.vol_b = env_volume[1];
    res.vol_n = env_volume[2];
    res.sweep = shadow_freq;
    return res;
  endfunction

  always @(posedge clk) begin
    sound_result_t got, want;
    if (rst) begin
      reset_state();
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (out_valid && !out_stall) begin
        got = '{read_data, ready_mask, volume_square_a, volume_square_b, volume_noise,
                volume_changed, sweep_frequency};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result transaction with none expected: %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got.rd !== want.rd || got.mask !== want.mask || got.vol_a !== want.vol_a ||
              got.vol_b !== want.vol_b || got.vol_n !== want.vol_n ||
              got.changed !== want.changed || got.sweep !== want.sweep) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: rd %h/%h mask %h/%h vol %h%h%h/%h%h%h chg %h/%h sw %h/%h",
                       want.rd, got.rd, want.mask, got.mask, want.vol_a, want.vol_b,
                       want.vol_n, got.vol_a, got.vol_b, got.vol_n, want.changed,
                       got.changed, want.sweep, got.sweep);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(op, address, write_data, cycles));
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/tb_sound_unit_frame_sequencer_top.sv =====
`timescale 1ns / 100ps
// Testbench top of the sound unit frame sequencer: drives bus, tick and clear
// transactions and threshold writes, and gives the verdict.
// Depends on sufs_pkg, sufs_checker and the block's RTL.
module tb_sound_unit_frame_sequencer_top;
  import sufs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_READ;
  logic [15:0] address = 16'd0;
  logic [7:0]  write_data = 8'd0;
  logic [7:0]  cycles = 8'd0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic [3:0]  ready_mask, volume_square_a, volume_square_b, volume_noise;
  logic [2:0]  volume_changed;
  logic [15:0] sweep_frequency;
  int          errors, pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  always #2 clk = ~clk;

  sound_unit_frame_sequencer_top uut (.*);
  sufs_checker chk (.*);

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("tb_sound_unit_frame_sequencer_top: errors");
    $finish;
  end

  task automatic send(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
                      input logic [7:0] cyc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    address <= a;
    write_data <= d;
    cycles <= cyc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count);
    logic [1:0]  o;
    logic [15:0] a;
    int          r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      o = (r < 30) ? OP_READ : (r < 60) ? OP_WRITE : (r < 94) ? OP_TICK : OP_CLEAR;
      r = $urandom_range(99);
      if (r < 65) a = 16'hFF10 + $urandom_range(0, 22);
      else if (r < 85) a = 16'hFF30 + $urandom_range(0, 15);
      else a = $urandom;
      send(o, a, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 56;
    set_threshold(16'd1);
    send(OP_READ, 16'hFF10, 8'h00, 8'h00);
    send(OP_READ, 16'hFF26, 8'h00, 8'h00);
    send(OP_READ, 16'hFF15, 8'h00, 8'h00);
    send(OP_READ, 16'h0000, 8'h00, 8'h00);
    send(OP_READ, 16'hFFFF, 8'h00, 8'h00);
    send(OP_READ, 16'hFF30, 8'h00, 8'h00);
    send(OP_READ, 16'hFF3F, 8'h00, 8'h00);
    send(OP_WRITE, 16'hFF30, 8'hFF, 8'h00);
    send(OP_WRITE, 16'hFF3F, 8'h00, 8'h00);
    send(OP_WRITE, 16'hFFFF, 8'hAA, 8'h00);
    send(OP_WRITE, 16'hFF12, 8'hF9, 8'h00);
    send(OP_WRITE, 16'hFF11, 8'h00, 8'h00);
    send(OP_WRITE, 16'hFF13, 8'hFF, 8'h00);
    send(OP_WRITE, 16'hFF10, 8'h7F, 8'h00);
    send(OP_WRITE, 16'hFF14, 8'hC7, 8'h00);
    send(OP_TICK, 16'h0000, 8'h00, 8'h00);
    send(OP_TICK, 16'h0000, 8'h00, 8'hFF);
    send(OP_TICK, 16'h0000, 8'h00, 8'hFF);
    send(OP_TICK, 16'h0000, 8'h00, 8'hFF);
    send(OP_READ, 16'hFF26, 8'h00, 8'h00);
    send(OP_WRITE, 16'hFF26, 8'h00, 8'h00);
    send(OP_CLEAR, 16'h0000, 8'h00, 8'h00);
    send(OP_WRITE, 16'hFF26, 8'h80, 8'h00);
    send(OP_READ, 16'hFF26, 8'h00, 8'h00);
    random_items(380);

    send_idle_pct = 56;
    recv_idle_pct = 28;
    set_threshold(16'd65535);
    random_items(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_threshold(16'($urandom_range(2, 300)));
    hold_request = 1'b1;
    random_items(400);

    set_threshold(16'd8192);
    random_items(400);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb_sound_unit_frame_sequencer_top: clean");
    else
      $display("tb_sound_unit_frame_sequencer_top: errors");
    $finish;
  end

endmodule
